@@ rtl/core/two_level_branch_predictor_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the two-level branch predictor
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the synchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_BRANCH_PREDICTOR_MACROS_SVH
`define TWO_LEVEL_BRANCH_PREDICTOR_MACROS_SVH

// Same-cycle implication
`define TBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TBP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Invariant checked at every edge
`define TBP_ASSERT_ALW(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

`endif

@@ rtl/core/tbp_pkg.sv @@
// ---------------------------------------------------------------------------
// tbp_pkg
// Types, constants and helpers shared by the branch predictor modules.
// ---------------------------------------------------------------------------
package tbp_pkg;

    // Address mixing hash
    localparam logic [63:0] HASH_MUL_A = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] HASH_MUL_B = 64'hC4CE_B9FE_1A85_EC53;
    localparam int          HASH_SHIFT = 33;

    // Saturation limits
    localparam logic [1:0]  CTR_MAX   = 2'd3;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Width of the sequencer step index (covers up to 21 remainder steps)
    localparam int STEP_W = 5;

    // Register file
    localparam int   APB_ADDR_W       = 3;
    localparam logic REG_BRANCH_LIMIT = 1'b0;

    // Partial product select for the 64x64 low-half multiply
    localparam logic [1:0] PP_LL = 2'd0;
    localparam logic [1:0] PP_LH = 2'd1;
    localparam logic [1:0] PP_HL = 2'd2;

    // Accumulator operation
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              clr_en;
        logic              load;
        logic              mul_en;
        logic [1:0]        pp_sel;
        logic              mul_pass;
        logic [1:0]        acc_op;
        logic              mix;
        logic              hist_rd;
        logic              rem_step;
        logic [STEP_W-1:0] step;
        logic              ctr_rd;
        logic              update;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_dp_stat;

    // Number of shift-subtract steps that reduce a history modulo the pattern size
    function automatic int mod_steps(input int pat, input int hist_bits);
        int n;
        n = 0;
        for (int k = 0; k <= 20; k++) begin
            if ((longint'(pat) << k) < (longint'(1) << hist_bits)) begin
                n++;
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/core/tbp_branch_if.sv @@
// ---------------------------------------------------------------------------
// tbp_branch_if
// Resolved branch channel: address and outcome with valid/ready handshake.
// ---------------------------------------------------------------------------
interface tbp_branch_if;
    logic        valid;
    logic        ready;
    logic [63:0] branch_address;
    logic        taken;

    modport source (output valid, output branch_address, output taken, input ready);
    modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

@@ rtl/core/tbp_result_if.sv @@
// ---------------------------------------------------------------------------
// tbp_result_if
// Prediction result channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface tbp_result_if;
    logic        valid;
    logic        ready;
    logic        prediction;
    logic        correct;
    logic [31:0] seen_total;
    logic [31:0] taken_total;
    logic [31:0] correct_total;
    logic        limit_flag;

    modport source (
        output valid, output prediction, output correct, output seen_total,
        output taken_total, output correct_total, output limit_flag,
        input ready
    );
    modport sink (
        input valid, input prediction, input correct, input seen_total,
        input taken_total, input correct_total, input limit_flag,
        output ready
    );
endinterface

@@ rtl/core/tbp_ctrl.sv @@
// ---------------------------------------------------------------------------
// tbp_ctrl
// Sequencer: table clearing after reset, hash multiply steps, table reads,
// remainder steps and the final update of one branch item.
// ---------------------------------------------------------------------------
`include "two_level_branch_predictor_macros.svh"

module tbp_ctrl #(
    parameter int MOD_STEPS = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tbp_pkg::t_dp_stat i_stat,
    output tbp_pkg::t_dp_cmd  o_cmd
);
    import tbp_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_MIX    = 3'd3;
    localparam logic [2:0] S_HREAD  = 3'd4;
    localparam logic [2:0] S_MOD    = 3'd5;
    localparam logic [2:0] S_CREAD  = 3'd6;
    localparam logic [2:0] S_UPDATE = 3'd7;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(3);

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_pass;
    logic              n_pass;

    // Next state and command decode
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_step     = r_step;
        n_pass     = r_pass;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                    n_step     = '0;
                    n_pass     = 1'b0;
                end
            end
            S_MUL: begin
                o_cmd.mul_pass = r_pass;
                case (r_step[1:0])
                    2'd0: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.pp_sel = PP_LL;
                    end
                    2'd1: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.pp_sel = PP_LH;
                        o_cmd.acc_op = ACC_LOAD;
                    end
                    2'd2: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.pp_sel = PP_HL;
                        o_cmd.acc_op = ACC_ADD;
                    end
                    default: begin
                        o_cmd.acc_op = ACC_ADD;
                    end
                endcase
                if (r_step == MUL_LAST) begin
                    n_step  = '0;
                    n_state = S_MIX;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                if (r_pass) begin
                    n_state = S_HREAD;
                end else begin
                    n_pass  = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_HREAD: begin
                o_cmd.hist_rd = 1'b1;
                if (MOD_STEPS > 0) begin
                    n_step  = STEP_W'(MOD_STEPS - 1);
                    n_state = S_MOD;
                end else begin
                    n_state = S_CREAD;
                end
            end
            S_MOD: begin
                o_cmd.rem_step = 1'b1;
                o_cmd.step     = r_step;
                if (r_step == '0) begin
                    n_state = S_CREAD;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_CREAD: begin
                o_cmd.ctr_rd = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pass  <= n_pass;
        end
    end

    `TBP_ASSERT_IMP(a_update_free, i_clk, i_rst_n, o_cmd.update, i_stat.out_free, "update while output busy")
    `TBP_ASSERT_ALW(a_cmd_excl, i_clk, i_rst_n, $onehot0({o_cmd.clr_en, o_cmd.load, o_cmd.hist_rd, o_cmd.ctr_rd, o_cmd.update}), "conflicting commands")
    `TBP_ASSERT_NXT(a_load_mul, i_clk, i_rst_n, o_cmd.load, r_state == S_MUL, "load not followed by hash")

endmodule

@@ rtl/core/tbp_datapath.sv @@
// ---------------------------------------------------------------------------
// tbp_datapath
// Address hash on a shared 32x32 multiplier, history and pattern tables,
// history remainder, running counts and the result register.
// ---------------------------------------------------------------------------
`include "two_level_branch_predictor_macros.svh"

module tbp_datapath #(
    parameter int HISTORY_ENTRIES = 512,
    parameter int PATTERN_ENTRIES = 4096,
    parameter int HISTORY_BITS    = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tbp_pkg::t_dp_cmd  i_cmd,
    output tbp_pkg::t_dp_stat o_stat,
    input  logic [63:0]       i_branch_address,
    input  logic              i_taken,
    input  logic [31:0]       i_branch_limit,
    tbp_result_if.source      o_result
);
    import tbp_pkg::*;

    localparam int HIW         = $clog2(HISTORY_ENTRIES);
    localparam int PIW         = $clog2(PATTERN_ENTRIES);
    localparam int CLR_ENTRIES = (HISTORY_ENTRIES > PATTERN_ENTRIES) ?
                                 HISTORY_ENTRIES : PATTERN_ENTRIES;
    localparam int CLW         = $clog2(CLR_ENTRIES);

    localparam logic [HIW-1:0] HIDX_MASK = HIW'(HISTORY_ENTRIES - 1);
    localparam logic [63:0]    PAT_WIDE  = 64'(PATTERN_ENTRIES);

    // Tables
    logic [HISTORY_BITS-1:0] r_hist_mem [HISTORY_ENTRIES];
    logic [1:0]              r_ctr_mem  [PATTERN_ENTRIES];

    // Hash registers
    logic [63:0] r_x;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic        r_taken;

    // Table read data and remainder
    logic [HISTORY_BITS-1:0] r_hist_q;
    logic [HISTORY_BITS-1:0] r_rem;
    logic [1:0]              r_ctr_q;
    logic [CLW-1:0]          r_clr_addr;

    // Counts and result
    logic [31:0] r_seen;
    logic [31:0] r_taken_cnt;
    logic [31:0] r_correct_cnt;
    logic        r_out_valid;
    logic        r_pred;
    logic        r_ok;
    logic        r_limit_hit;

    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             mul_k;
    logic [63:0]             mul_full;
    logic [HIW-1:0]          hidx;
    logic [PIW-1:0]          pidx;
    logic [HISTORY_BITS-1:0] rem_cmp;
    logic [HISTORY_BITS-1:0] hist_next;
    logic [1:0]              ctr_next;
    logic                    pred;
    logic                    ok;
    logic [31:0]             seen_next;
    logic [31:0]             taken_next;
    logic [31:0]             correct_next;
    logic                    limit_hit;

    // Select multiplier operand halves
    always_comb begin
        mul_k    = i_cmd.mul_pass ? HASH_MUL_B : HASH_MUL_A;
        mul_a    = (i_cmd.pp_sel == PP_HL) ? r_x[63:32] : r_x[31:0];
        mul_b    = (i_cmd.pp_sel == PP_LH) ? mul_k[63:32] : mul_k[31:0];
        mul_full = {32'd0, mul_a} * {32'd0, mul_b};
    end

    // Table indexes and remainder compare
    assign hidx      = r_x[HIW-1:0] & HIDX_MASK;
    assign pidx      = PIW'(r_rem);
    assign rem_cmp   = HISTORY_BITS'(PAT_WIDE << i_cmd.step);
    assign hist_next = HISTORY_BITS'({r_hist_q, r_taken});

    // Prediction, counter move and saturating counts
    always_comb begin
        pred = r_ctr_q[1];
        ok   = (pred == r_taken);
        if (r_taken) begin
            ctr_next = (r_ctr_q == CTR_MAX) ? r_ctr_q : r_ctr_q + 2'd1;
        end else begin
            ctr_next = (r_ctr_q == 2'd0) ? r_ctr_q : r_ctr_q - 2'd1;
        end
        seen_next    = (r_seen == COUNT_MAX) ? r_seen : r_seen + 32'd1;
        taken_next   = (r_taken && r_taken_cnt != COUNT_MAX) ?
                       r_taken_cnt + 32'd1 : r_taken_cnt;
        correct_next = (ok && r_correct_cnt != COUNT_MAX) ?
                       r_correct_cnt + 32'd1 : r_correct_cnt;
        limit_hit    = (i_branch_limit != 32'd0) && (seen_next == i_branch_limit);
    end

    // Hash datapath: pre-mix, partial products, accumulate, mix
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_branch_address ^ (i_branch_address >> HASH_SHIFT);
            r_taken <= i_taken;
        end else if (i_cmd.mix) begin
            r_x <= r_acc ^ (r_acc >> HASH_SHIFT);
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_full;
        end
        case (i_cmd.acc_op)
            ACC_HOLD: r_acc <= r_acc;
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + {r_prod[31:0], 32'd0};
            default:  r_acc <= r_acc;
        endcase
    end

    // Tables: clear sweep, registered reads, write back on update
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            if ({1'b0, r_clr_addr} < (CLW + 1)'(HISTORY_ENTRIES)) begin
                r_hist_mem[HIW'(r_clr_addr)] <= '0;
            end
            if ({1'b0, r_clr_addr} < (CLW + 1)'(PATTERN_ENTRIES)) begin
                r_ctr_mem[PIW'(r_clr_addr)] <= '0;
            end
        end
        if (i_cmd.update) begin
            r_hist_mem[hidx] <= hist_next;
            r_ctr_mem[pidx]  <= ctr_next;
        end
        if (i_cmd.hist_rd) begin
            r_hist_q <= r_hist_mem[hidx];
            r_rem    <= r_hist_mem[hidx];
        end else if (i_cmd.rem_step && (r_rem >= rem_cmp)) begin
            r_rem <= r_rem - rem_cmp;
        end
        if (i_cmd.ctr_rd) begin
            r_ctr_q <= r_ctr_mem[pidx];
        end
    end

    // Control state: clear address, counts, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr    <= '0;
            r_seen        <= '0;
            r_taken_cnt   <= '0;
            r_correct_cnt <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + CLW'(1);
            end
            if (i_cmd.update) begin
                r_seen        <= seen_next;
                r_taken_cnt   <= taken_next;
                r_correct_cnt <= correct_next;
                r_out_valid   <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_pred      <= pred;
            r_ok        <= ok;
            r_limit_hit <= limit_hit;
        end
    end

    // Drive result channel; totals hold until the next update
    assign o_result.valid         = r_out_valid;
    assign o_result.prediction    = r_pred;
    assign o_result.correct       = r_ok;
    assign o_result.seen_total    = r_seen;
    assign o_result.taken_total   = r_taken_cnt;
    assign o_result.correct_total = r_correct_cnt;
    assign o_result.limit_flag    = r_limit_hit;

    assign o_stat.clr_last = (r_clr_addr == CLW'(CLR_ENTRIES - 1));
    assign o_stat.out_free = !r_out_valid || o_result.ready;

    `TBP_ASSERT_NXT(a_update_valid, i_clk, i_rst_n, i_cmd.update, r_out_valid, "result not presented after update")
    `TBP_ASSERT_IMP(a_seen_mono, i_clk, i_rst_n, $past(i_rst_n), r_seen >= $past(r_seen), "seen count went down")

endmodule

@@ rtl/core/two_level_branch_predictor.sv @@
// ---------------------------------------------------------------------------
// two_level_branch_predictor
// Items are handled one at a time: a new item is accepted only after the previous one has been
// written to the result register; the hash steps share one 32x32 multiplier.
// Reset: clears counts and control, then sweeps every entry of both tables
// (max(HISTORY_ENTRIES, PATTERN_ENTRIES), 4096 by default) before the first item is taken.
// ---------------------------------------------------------------------------
module two_level_branch_predictor #(
    parameter int HISTORY_ENTRIES = 512,
    parameter int PATTERN_ENTRIES = 4096,
    parameter int HISTORY_BITS    = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tbp_branch_if.sink                     i_branch,
    tbp_result_if.source                   o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import tbp_pkg::*;

    localparam int MOD_STEPS = mod_steps(PATTERN_ENTRIES, HISTORY_BITS);

    logic [31:0] r_branch_limit;
    logic        in_ready;
    t_dp_cmd     dp_cmd;
    t_dp_stat    dp_stat;

    // Configuration register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branch_limit <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_BRANCH_LIMIT)) begin
            r_branch_limit <= pwdata;
        end
    end

    // Register read back
    assign prdata = (paddr[2] == REG_BRANCH_LIMIT) ? r_branch_limit : 32'd0;
    assign pready = 1'b1;

    assign i_branch.ready = in_ready;

    tbp_ctrl #(
        .MOD_STEPS (MOD_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_branch.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    tbp_datapath #(
        .HISTORY_ENTRIES (HISTORY_ENTRIES),
        .PATTERN_ENTRIES (PATTERN_ENTRIES),
        .HISTORY_BITS    (HISTORY_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_branch_address (i_branch.branch_address),
        .i_taken          (i_branch.taken),
        .i_branch_limit   (r_branch_limit),
        .o_result         (o_result)
    );

endmodule

@@ verif/two_level_branch_predictor_tb.sv @@
// ---------------------------------------------------------------------------
// two_level_branch_predictor_tb
// Drives resolved branches into the predictor and checks every result
// against a local PAg model: address hash, per-branch history, shared
// 2-bit counters, saturating running counts and the branch limit flag.
// A short directed table comes first, then random loop-shaped branch
// streams over several idle/stall phases, with the limit reprogrammed
// between phases through the APB port.
// ---------------------------------------------------------------------------
module two_level_branch_predictor_tb;

    localparam int HIST_ENTRIES = 512;
    localparam int PAT_ENTRIES  = 4096;
    localparam int HIST_BITS    = 12;

    localparam logic [63:0] MIX_MUL_A = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] MIX_MUL_B = 64'hC4CE_B9FE_1A85_EC53;
    localparam int          MIX_SHIFT = 33;
    localparam logic [1:0]  CTR_TOP   = 2'd3;
    localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

    localparam logic [tbp_pkg::APB_ADDR_W-1:0] LIMIT_ADDR =
        tbp_pkg::APB_ADDR_W'(4 * int'(tbp_pkg::REG_BRANCH_LIMIT));
    localparam logic [tbp_pkg::APB_ADDR_W-1:0] SPARE_ADDR =
        tbp_pkg::APB_ADDR_W'(4 * (int'(tbp_pkg::REG_BRANCH_LIMIT) + 1));
    localparam logic [31:0] LIMIT_OFF = 32'd0;

    localparam int DRAIN_CYCLES    = 20;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int POOL_SIZE       = 24;
    localparam int DIRECTED_ROWS   = 21;

    typedef struct packed {
        logic        prediction;
        logic        correct;
        logic [31:0] seen_total;
        logic [31:0] taken_total;
        logic [31:0] correct_total;
        logic        limit_flag;
    } t_branch_outcome;

    typedef struct {
        logic [63:0]     addr;
        logic            taken;
        bit              typed;
        t_branch_outcome want;
    } t_branch_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [tbp_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tbp_branch_if branch_ch ();
    tbp_result_if result_ch ();

    two_level_branch_predictor #(
        .HISTORY_ENTRIES (HIST_ENTRIES),
        .PATTERN_ENTRIES (PAT_ENTRIES),
        .HISTORY_BITS    (HIST_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_branch (branch_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Model state
    logic [HIST_BITS-1:0] branch_history [HIST_ENTRIES];
    logic [1:0]           pattern_ctr    [PAT_ENTRIES];
    logic [31:0]          seen_count;
    logic [31:0]          taken_count;
    logic [31:0]          correct_count;
    logic [31:0]          branch_limit;

    t_branch_outcome pending_outcomes [$];
    int              mismatch_count;
    int              send_idle_pct;
    int              recv_stall_pct;

    // Loop-shaped branches replayed by the random part
    logic [63:0] pool_addr   [POOL_SIZE];
    int          pool_period [POOL_SIZE];
    int          pool_trip   [POOL_SIZE];

    // Directed stimulus; first rows right after reset with a limit of one
    t_branch_row directed_rows [DIRECTED_ROWS] = '{
        '{64'h0000_0000_0000_0000, 1'b0, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd0, 32'd1, 1'b1}},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 32'd2, 32'd1, 32'd1, 1'b0}},
        '{64'h8000_0000_0000_0000, 1'b1, 1'b0, '0},
        '{64'h0000_0001_0000_0000, 1'b1, 1'b0, '0},
        '{64'h0000_0002_0000_0000, 1'b1, 1'b0, '0},
        '{64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, '0},
        '{64'hFFFF_FFFE_0000_0000, 1'b0, 1'b0, '0},
        '{64'h0000_0000_0000_0001, 1'b0, 1'b0, '0},
        '{64'h5555_5555_5555_5555, 1'b0, 1'b0, '0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
        '{64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0, '0},
        '{64'h0000_0000_0040_1000, 1'b1, 1'b0, '0},
        '{64'h0000_0000_0040_1000, 1'b1, 1'b0, '0},
        '{64'h0000_0000_0040_1000, 1'b1, 1'b0, '0},
        '{64'h0000_0000_0040_1000, 1'b0, 1'b0, '0},
        '{64'h0000_0000_0040_1000, 1'b1, 1'b0, '0},
        '{64'h0000_0000_0040_1000, 1'b1, 1'b0, '0},
        '{64'h0000_0000_0040_1000, 1'b0, 1'b0, '0},
        '{64'h0000_0000_0040_1000, 1'b1, 1'b0, '0},
        '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
        '{64'h0000_0000_0040_1000, 1'b1, 1'b0, '0}
    };

    // 64-bit address mixer: xor-shift, multiply, xor-shift, multiply, xor-shift
    function automatic logic [63:0] mix_address(input logic [63:0] addr);
        logic [63:0] x;
        x = addr;
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_MUL_A;
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_MUL_B;
        x = x ^ (x >> MIX_SHIFT);
        return x;
    endfunction

    function automatic logic [31:0] bump_count(input logic [31:0] v);
        return (v == COUNT_TOP) ? v : v + 32'd1;
    endfunction

    // Predict one branch and advance the model tables and counts
    function automatic t_branch_outcome predict_branch(input logic [63:0] addr,
                                                       input logic taken);
        t_branch_outcome      r;
        logic [63:0]          h;
        int unsigned          hidx;
        int unsigned          pidx;
        logic [HIST_BITS-1:0] hist;
        logic [1:0]           ctr;
        h    = mix_address(addr);
        hidx = int'(h & 64'(HIST_ENTRIES - 1));
        hist = branch_history[hidx];
        pidx = int'(hist) % PAT_ENTRIES;
        ctr  = pattern_ctr[pidx];

        r.prediction = (ctr >= 2'd2);
        r.correct    = (r.prediction == taken);

        seen_count = bump_count(seen_count);
        if (taken) begin
            taken_count = bump_count(taken_count);
        end
        if (r.correct) begin
            correct_count = bump_count(correct_count);
        end

        // Move the counter one step toward the outcome, shift history
        if (taken && ctr != CTR_TOP) begin
            ctr = ctr + 2'd1;
        end else if (!taken && ctr != 2'd0) begin
            ctr = ctr - 2'd1;
        end
        pattern_ctr[pidx]    = ctr;
        branch_history[hidx] = HIST_BITS'({hist, taken});

        r.seen_total    = seen_count;
        r.taken_total   = taken_count;
        r.correct_total = correct_count;
        r.limit_flag    = (branch_limit != LIMIT_OFF) && (seen_count == branch_limit);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one branch, account for idle gaps, predict on acceptance
    task automatic send_branch(input logic [63:0] addr, input logic taken,
                               input bit typed, input t_branch_outcome want);
        t_branch_outcome predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            branch_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        branch_ch.valid          <= 1'b1;
        branch_ch.branch_address <= addr;
        branch_ch.taken          <= taken;
        do @(posedge i_clk); while (!branch_ch.ready);
        predicted = predict_branch(addr, taken);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    // Drop valid and hold until every outstanding result is back
    task automatic wait_all_results();
        branch_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [tbp_pkg::APB_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [tbp_pkg::APB_ADDR_W-1:0] addr,
                            output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program the limit and read it back
    task automatic set_branch_limit(input logic [31:0] value);
        logic [31:0] rd;
        apb_write(LIMIT_ADDR, value);
        branch_limit = value;
        apb_read(LIMIT_ADDR, rd);
        if (rd !== value) begin
            report_mismatch("branch_limit readback", 64'(rd), 64'(value));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check each result against the oldest expectation; pick ready
    always @(posedge i_clk) begin : result_check
        t_branch_outcome want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result with no branch outstanding",
                                64'(result_ch.seen_total), 64'd0);
            end else begin
                want = pending_outcomes.pop_front();
                if (result_ch.prediction !== want.prediction)
                    report_mismatch("prediction", 64'(result_ch.prediction),
                                    64'(want.prediction));
                if (result_ch.correct !== want.correct)
                    report_mismatch("correct", 64'(result_ch.correct), 64'(want.correct));
                if (result_ch.seen_total !== want.seen_total)
                    report_mismatch("seen_total", 64'(result_ch.seen_total),
                                    64'(want.seen_total));
                if (result_ch.taken_total !== want.taken_total)
                    report_mismatch("taken_total", 64'(result_ch.taken_total),
                                    64'(want.taken_total));
                if (result_ch.correct_total !== want.correct_total)
                    report_mismatch("correct_total", 64'(result_ch.correct_total),
                                    64'(want.correct_total));
                if (result_ch.limit_flag !== want.limit_flag)
                    report_mismatch("limit_flag", 64'(result_ch.limit_flag),
                                    64'(want.limit_flag));
            end
        end
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin : stimulus
        int          p;
        int          k;
        int          slot;
        int          pick;
        logic [63:0] addr;
        logic        taken;
        logic [31:0] rd;

        // Known values on every input from time zero
        i_rst_n                  = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        branch_ch.valid          = 1'b0;
        branch_ch.branch_address = '0;
        branch_ch.taken          = 1'b0;
        send_idle_pct            = 0;
        recv_stall_pct           = 0;
        mismatch_count           = 0;

        // Model reset state
        for (k = 0; k < HIST_ENTRIES; k++) branch_history[k] = '0;
        for (k = 0; k < PAT_ENTRIES; k++) pattern_ctr[k] = '0;
        seen_count    = '0;
        taken_count   = '0;
        correct_count = '0;
        branch_limit  = LIMIT_OFF;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Limit resets to zero; a write past the last register is ignored
        apb_read(LIMIT_ADDR, rd);
        if (rd !== LIMIT_OFF) begin
            report_mismatch("branch_limit after reset", 64'(rd), 64'(LIMIT_OFF));
        end
        set_branch_limit(32'd1);
        apb_write(SPARE_ADDR, COUNT_TOP);
        apb_read(LIMIT_ADDR, rd);
        if (rd !== branch_limit) begin
            report_mismatch("branch_limit after spare write", 64'(rd), 64'(branch_limit));
        end

        // Directed table
        for (k = 0; k < DIRECTED_ROWS; k++) begin
            send_branch(directed_rows[k].addr, directed_rows[k].taken,
                        directed_rows[k].typed, directed_rows[k].want);
        end

        // Random phases: new limit and idle mix each time
        for (p = 0; p < PHASES; p++) begin
            wait_all_results();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            case (p)
                0:       set_branch_limit(LIMIT_OFF);
                1:       set_branch_limit(COUNT_TOP);
                2:       set_branch_limit(seen_count + 32'd100);
                3:       set_branch_limit(seen_count + 32'd1);
                4:       set_branch_limit($urandom);
                5:       set_branch_limit(seen_count + 32'(ITEMS_PER_PHASE));
                6:       set_branch_limit(seen_count + 32'($urandom_range(1, ITEMS_PER_PHASE)));
                default: set_branch_limit(LIMIT_OFF);
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase

            // Fresh set of loop branches
            for (k = 0; k < POOL_SIZE; k++) begin
                pool_addr[k]   = {$urandom, $urandom};
                pool_period[k] = $urandom_range(1, 9);
                pool_trip[k]   = 0;
            end

            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == ITEMS_PER_PHASE / 2) begin
                    wait_all_results();
                end
                pick = $urandom_range(99);
                if (pick < 85) begin
                    // Loop branch: taken until its trip count wraps
                    slot  = $urandom_range(POOL_SIZE - 1);
                    addr  = pool_addr[slot];
                    taken = (pool_trip[slot] % pool_period[slot]) != pool_period[slot] - 1;
                    if (pick < 6) begin
                        taken = 1'($urandom_range(1));
                    end
                    pool_trip[slot]++;
                end else begin
                    addr  = {$urandom, $urandom};
                    taken = 1'($urandom_range(1));
                end
                send_branch(addr, taken, 1'b0, '0);
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop if the block hangs
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
